>>> hdl/coa_pkg.sv
// shared types and constants of the clock offset averager
package coa_pkg;

  localparam int TIME_W         = 32;
  localparam int OFFSET_W       = 32;
  localparam int THR_W          = 10;
  localparam int COUNT_OUT_W    = 10;
  localparam int SMOOTH_W       = 35;
  localparam int SMOOTH_RECIP_W = 34;
  localparam int SMOOTH_SHIFT   = 36;

  // ceil(2^36 / 6), exact quotient for magnitudes below 2^35
  localparam logic [SMOOTH_RECIP_W-1:0] SMOOTH_RECIP = 34'h2_AAAA_AAAB;

  localparam logic [THR_W-1:0] SYNC_THR_RESET = 10'd256;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] server_time;
    logic [TIME_W-1:0] local_time;
    logic [TIME_W-1:0] round_trip;
  } in_item_t;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] mean_offset;
    logic signed [OFFSET_W-1:0] smoothed_offset;
    logic [COUNT_OUT_W-1:0]     sample_count;
    logic                       synchronised;
  } out_item_t;

  typedef struct packed {
    logic accept_sample;
    logic clear;
    logic sub_old;
    logic add_new;
    logic div_load;
    logic div_step;
    logic mean_fix;
    logic smooth_prep;
    logic smooth_load;
    logic smooth_mul_lo;
    logic smooth_mul_hi;
    logic smooth_fix;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

>>> hdl/coa_ifs.sv
// channel interfaces of the clock offset averager

interface coa_in_if;
  logic              valid;
  logic              ready;
  coa_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface coa_out_if;
  logic               valid;
  logic               ready;
  coa_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface coa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [coa_pkg::THR_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/coa_dp.sv
// datapath: offset ring, running sum, radix-4 mean divider, reciprocal smoothing and output register
module coa_dp #(
  parameter int DEPTH = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  coa_pkg::ctrl_cmd_t         cmd,
  output coa_pkg::dp_sts_t           sts,
  input  coa_pkg::in_item_t          in_data,
  input  logic                       cfg_we,
  input  logic [coa_pkg::THR_W-1:0]  cfg_data,
  output coa_pkg::out_item_t         out_data
);
  import coa_pkg::*;

  localparam int AW         = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = OFFSET_W + $clog2(DEPTH);
  localparam int DVS_W      = CNT_W;
  localparam int DIV_W      = SUM_W + (SUM_W % 2);
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int MAG_W      = SMOOTH_W - 1;
  localparam int HALF_W     = SMOOTH_RECIP_W / 2;
  localparam int PP_W       = MAG_W + HALF_W;
  localparam int PROD_W     = MAG_W + SMOOTH_RECIP_W;

  logic [OFFSET_W-1:0]        ring_mem [DEPTH];
  logic [OFFSET_W-1:0]        rd_r;
  logic [OFFSET_W-1:0]        delta_r;
  logic [AW-1:0]              widx_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [OFFSET_W-1:0] mean_r;
  logic signed [OFFSET_W-1:0] sm_r;
  logic signed [SMOOTH_W-1:0] x_r;
  logic [THR_W-1:0]           thr_r;
  logic [DIV_W-1:0]           dvd_r;
  logic [DVS_W-1:0]           rem_r;
  logic [DVS_W-1:0]           dvs_r;
  logic                       neg_r;
  logic [STEP_W-1:0]          step_r;
  logic [MAG_W-1:0]           mag_r;
  logic                       sm_neg_r;
  logic [PROD_W-1:0]          prod_r;
  out_item_t                  out_r;

  logic                       full;
  logic signed [DIV_W-1:0]    div_src;
  logic [DVS_W:0]             t1;
  logic [DVS_W:0]             t2;
  logic                       ge1;
  logic                       ge2;
  logic [DVS_W-1:0]           r1;
  logic [DVS_W-1:0]           r2;
  logic [DIV_W-1:0]           d1;
  logic [DIV_W-1:0]           d2;
  logic [OFFSET_W-1:0]        q;
  logic                       round_up;
  logic [CNT_W+THR_W-1:0]     cnt_ext;
  logic [CNT_W+THR_W-1:0]     thr_ext;
  logic [HALF_W-1:0]          recip_part;
  logic [PP_W-1:0]            pp;
  logic [OFFSET_W-1:0]        sm_q;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign div_src  = DIV_W'(sum_r);
  assign q        = dvd_r[OFFSET_W-1:0];
  assign round_up = (rem_r > (dvs_r >> 1));
  assign cnt_ext  = {{THR_W{1'b0}}, cnt_r};
  assign thr_ext  = {{CNT_W{1'b0}}, thr_r};

  // divide by six: low then high half of the reciprocal
  assign recip_part = cmd.smooth_mul_hi ? SMOOTH_RECIP[SMOOTH_RECIP_W-1:HALF_W]
                                        : SMOOTH_RECIP[HALF_W-1:0];
  assign pp         = mag_r * recip_part;
  assign sm_q       = prod_r[SMOOTH_SHIFT +: OFFSET_W];

  // two restoring steps per cycle
  always_comb begin
    t1  = {rem_r, dvd_r[DIV_W-1]};
    ge1 = (t1 >= {1'b0, dvs_r});
    r1  = ge1 ? DVS_W'(t1 - {1'b0, dvs_r}) : t1[DVS_W-1:0];
    d1  = {dvd_r[DIV_W-2:0], ge1};
    t2  = {r1, d1[DIV_W-1]};
    ge2 = (t2 >= {1'b0, dvs_r});
    r2  = ge2 ? DVS_W'(t2 - {1'b0, dvs_r}) : t2[DVS_W-1:0];
    d2  = {d1[DIV_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      rd_r <= ring_mem[widx_r];
    end
    if (cmd.add_new) begin
      ring_mem[widx_r] <= delta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
      sm_r   <= '0;
      thr_r  <= SYNC_THR_RESET;
      step_r <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
      if (cmd.clear) begin
        widx_r <= '0;
        cnt_r  <= '0;
        sum_r  <= '0;
        sm_r   <= '0;
      end
      if (cmd.sub_old && full) begin
        sum_r <= sum_r - SUM_W'($signed(rd_r));
      end
      if (cmd.add_new) begin
        sum_r  <= sum_r + SUM_W'($signed(delta_r));
        widx_r <= (widx_r == AW'(DEPTH - 1)) ? '0 : widx_r + 1'b1;
        if (!full) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.smooth_fix) begin
        sm_r <= sm_neg_r ? $signed(-sm_q) : $signed(sm_q);
      end
      if (cmd.div_load) begin
        step_r <= STEP_W'(DIV_STEPS);
      end else if (cmd.div_step) begin
        step_r <= step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      delta_r <= in_data.server_time + (in_data.round_trip >> 1) - in_data.local_time;
    end
    if (cmd.clear) begin
      mean_r <= '0;
    end
    if (cmd.div_load) begin
      neg_r <= div_src[DIV_W-1];
      dvd_r <= div_src[DIV_W-1] ? DIV_W'(-div_src) : DIV_W'(div_src);
      rem_r <= '0;
      dvs_r <= DVS_W'(cnt_r);
    end else if (cmd.div_step) begin
      dvd_r <= d2;
      rem_r <= r2;
    end
    // rounding to nearest, ties toward zero, folded into the sign fix
    if (cmd.mean_fix) begin
      if (neg_r) begin
        mean_r <= round_up ? $signed(~q) : $signed(~q + 1'b1);
      end else begin
        mean_r <= $signed(q + OFFSET_W'(round_up));
      end
    end
    if (cmd.smooth_prep) begin
      x_r <= (SMOOTH_W'(sm_r) <<< 2) + SMOOTH_W'(sm_r) + SMOOTH_W'(mean_r);
    end
    if (cmd.smooth_load) begin
      sm_neg_r <= x_r[SMOOTH_W-1];
      mag_r    <= x_r[SMOOTH_W-1] ? MAG_W'(-x_r) : MAG_W'(x_r);
    end
    if (cmd.smooth_mul_lo) begin
      prod_r <= PROD_W'(pp);
    end
    if (cmd.smooth_mul_hi) begin
      prod_r <= prod_r + {pp, {HALF_W{1'b0}}};
    end
    if (cmd.out_load) begin
      out_r.mean_offset     <= mean_r;
      out_r.smoothed_offset <= sm_r;
      out_r.sample_count    <= cnt_ext[COUNT_OUT_W-1:0];
      out_r.synchronised    <= (cnt_ext >= thr_ext);
    end
  end

  assign sts.div_last = (step_r == STEP_W'(1));
  assign out_data     = out_r;

endmodule

>>> hdl/coa_ctrl.sv
// controller: sequences one item through the datapath and owns the handshakes
module coa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output coa_pkg::ctrl_cmd_t  cmd,
  input  coa_pkg::dp_sts_t    sts
);
  import coa_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUB      = 4'd1;
  localparam logic [3:0] S_ADD      = 4'd2;
  localparam logic [3:0] S_LD_MEAN  = 4'd3;
  localparam logic [3:0] S_DIV_MEAN = 4'd4;
  localparam logic [3:0] S_FIX_MEAN = 4'd5;
  localparam logic [3:0] S_PREP_SM  = 4'd6;
  localparam logic [3:0] S_LD_SM    = 4'd7;
  localparam logic [3:0] S_MUL_LO   = 4'd8;
  localparam logic [3:0] S_MUL_HI   = 4'd9;
  localparam logic [3:0] S_FIX_SM   = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;
  logic       in_xfer;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_kind == KIND_CLEAR) begin
            cmd.clear = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.accept_sample = 1'b1;
            state_nxt         = S_SUB;
          end
        end
      end
      S_SUB: begin
        cmd.sub_old = 1'b1;
        state_nxt   = S_ADD;
      end
      S_ADD: begin
        cmd.add_new = 1'b1;
        state_nxt   = S_LD_MEAN;
      end
      S_LD_MEAN: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV_MEAN;
      end
      S_DIV_MEAN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIX_MEAN;
        end
      end
      S_FIX_MEAN: begin
        cmd.mean_fix = 1'b1;
        state_nxt    = S_PREP_SM;
      end
      S_PREP_SM: begin
        cmd.smooth_prep = 1'b1;
        state_nxt       = S_LD_SM;
      end
      S_LD_SM: begin
        cmd.smooth_load = 1'b1;
        state_nxt       = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.smooth_mul_lo = 1'b1;
        state_nxt         = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.smooth_mul_hi = 1'b1;
        state_nxt         = S_FIX_SM;
      end
      S_FIX_SM: begin
        cmd.smooth_fix = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // at most one datapath action per cycle
  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept_sample, cmd.clear, cmd.sub_old, cmd.add_new, cmd.div_load,
              cmd.div_step, cmd.mean_fix, cmd.smooth_prep, cmd.smooth_load,
              cmd.smooth_mul_lo, cmd.smooth_mul_hi, cmd.smooth_fix, cmd.out_load}))
    else $error("more than one datapath command");

  // a result never overwrites one still waiting
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_div_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |=> (state_r == S_DIV_MEAN))
    else $error("divider load not followed by steps");

  a_mean_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_MEAN && sts.div_last) |=> (state_r == S_FIX_MEAN))
    else $error("mean division did not finish");

endmodule

>>> hdl/clock_offset_averager.sv
// top level of the clock offset averager
//
// in_ch carries one item per transfer: kind selects a timing sample or a
// clear. a sample adds server_time + round_trip/2 - local_time to a ring of
// the last DEPTH offsets and a running sum; a clear empties the ring and the
// smoothed value. every item gives exactly one result on out_ch: rounded
// mean, smoothed offset, sample count and the synchronised flag.
// cfg_ch writes sync_threshold and is always ready; write it while idle.
// a sample passes through the sum update, S = ceil((32 + clog2(DEPTH))/2)
// radix-4 steps of the mean division, the smoothing and the output state.
// the divide by six of the smoothing multiplies by the reciprocal in halves.
// a clear goes straight to the output state and loads its result there.
// in_ch accepts one item at a time.
// the result sits in an output register, so a stalled out_ch does not stop
// the next item being taken; that item then waits before loading its result
// and in_ch.ready stays low until out_ch takes the older one.
// reset clears the count, sum, smoothed value and threshold (to 256).
module clock_offset_averager #(
  parameter int DEPTH = 512
) (
  input logic        clk,
  input logic        rst_n,
  coa_in_if.sink     in_ch,
  coa_out_if.source  out_ch,
  coa_cfg_if.sink    cfg_ch
);
  import coa_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ch.ready = 1'b1;

  coa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.data.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  coa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_ch.data),
    .cfg_we   (cfg_ch.valid && cfg_ch.ready),
    .cfg_data (cfg_ch.data),
    .out_data (out_ch.data)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the clock offset averager with its own offset predictor
module testbench;
  import coa_pkg::*;

  localparam int RING_DEPTH    = 512;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 64;

  typedef enum logic [1:0] {SPREAD_MIXED, SPREAD_LOW, SPREAD_HIGH} spread_t;

  logic clk = 1'b0;
  logic rst_n;

  coa_in_if  in_if ();
  coa_out_if out_if ();
  coa_cfg_if cfg_if ();

  clock_offset_averager #(.DEPTH(RING_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // offset predictor state
  logic signed [OFFSET_W-1:0] offset_hist [RING_DEPTH];
  int unsigned                hist_wr;
  int unsigned                hist_fill;
  longint                     hist_sum;
  int                         smooth_est;
  logic [THR_W-1:0]           sync_level;

  out_item_t pending_estimates [$];
  int        mismatch_count;
  bit        idling_on;
  bit        hold_req;
  int        hold_left;
  int        quiet_cycles;

  function automatic int offset_mean();
    longint n, q, r;
    n = hist_fill;
    if (n == 0) return 0;
    q = hist_sum / n;
    r = hist_sum % n;
    if (r < 0) r = -r;
    if (r > n / 2) q += (hist_sum < 0) ? -1 : 1;
    return int'(q);
  endfunction

  function automatic out_item_t predict_offsets(input in_item_t it);
    logic [OFFSET_W-1:0] delta;
    int                  mean;
    out_item_t           res;
    mean = 0;
    if (it.kind == KIND_CLEAR) begin
      hist_wr    = 0;
      hist_fill  = 0;
      hist_sum   = 0;
      smooth_est = 0;
    end else begin
      delta = it.server_time + (it.round_trip >> 1) - it.local_time;
      if (hist_fill >= RING_DEPTH) begin
        hist_sum -= offset_hist[hist_wr];
      end else begin
        hist_fill++;
      end
      offset_hist[hist_wr] = delta;
      hist_sum += $signed(delta);
      hist_wr = (hist_wr + 1) % RING_DEPTH;
      mean = offset_mean();
      smooth_est = int'((longint'(smooth_est) * 5 + longint'(mean)) / 6);
    end
    res.mean_offset     = mean;
    res.smoothed_offset = smooth_est;
    res.sample_count    = COUNT_OUT_W'(hist_fill);
    res.synchronised    = (hist_fill >= sync_level);
    return res;
  endfunction

  function automatic in_item_t raw_item(input logic kind, input logic [TIME_W-1:0] srv,
                                        input logic [TIME_W-1:0] loc,
                                        input logic [TIME_W-1:0] rt);
    in_item_t it;
    it.kind        = kind;
    it.server_time = srv;
    it.local_time  = loc;
    it.round_trip  = rt;
    return it;
  endfunction

  function automatic in_item_t offset_item(input logic [OFFSET_W-1:0] d);
    logic [TIME_W-1:0] srv, rt;
    srv = $urandom;
    rt  = $urandom_range(1) ? $urandom : $urandom_range(600);
    return raw_item(KIND_SAMPLE, srv, srv + (rt >> 1) - d, rt);
  endfunction

  function automatic in_item_t clear_item();
    return raw_item(KIND_CLEAR, $urandom, $urandom, $urandom);
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset(input spread_t spread);
    logic [OFFSET_W-1:0] d;
    case (spread)
      SPREAD_LOW:  d = 32'h8000_0000 + $urandom_range(15);
      SPREAD_HIGH: d = 32'h7fff_ffff - $urandom_range(15);
      default: begin
        case ($urandom_range(7))
          0, 1, 2, 3: d = $urandom_range(4000) - 2000;
          4:          d = 32'h7fff_ffff - $urandom_range(15);
          5:          d = 32'h8000_0000 + $urandom_range(15);
          default:    d = $urandom;
        endcase
      end
    endcase
    return d;
  endfunction

  task automatic send_item(input in_item_t it);
    out_item_t est;
    @(negedge clk);
    while (idling_on && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    est = predict_offsets(it);
    pending_estimates = {pending_estimates, est};
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] level);
    drain();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= level;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sync_level = level;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_after_reset();
    send_item(clear_item());
  endtask

  task automatic test_field_extremes();
    send_item(raw_item(KIND_SAMPLE, 32'h0, 32'h0, 32'h0));
    send_item(raw_item(KIND_SAMPLE, 32'hffff_ffff, 32'h0, 32'hffff_ffff));
    send_item(raw_item(KIND_SAMPLE, 32'h0, 32'hffff_ffff, 32'h0));
    send_item(raw_item(KIND_SAMPLE, 32'h0, 32'h8000_0000, 32'h0));
    send_item(raw_item(KIND_SAMPLE, 32'h7fff_ffff, 32'h0, 32'h1));
    send_item(raw_item(KIND_SAMPLE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_item(raw_item(KIND_SAMPLE, 32'h8000_0000, 32'h0, 32'h2));
  endtask

  task automatic test_rounding();
    send_item(clear_item());
    send_item(offset_item(-32'sd1));
    send_item(offset_item(-32'sd2));
    send_item(offset_item(-32'sd2));
    send_item(clear_item());
    send_item(offset_item(32'd1));
    send_item(offset_item(32'd2));
    send_item(offset_item(32'd2));
  endtask

  task automatic test_thresholds();
    set_threshold(10'd0);
    send_item(clear_item());
    send_item(offset_item(pick_offset(SPREAD_MIXED)));
    set_threshold(10'd1);
    send_item(clear_item());
    send_item(offset_item(pick_offset(SPREAD_MIXED)));
    set_threshold(10'd1023);
    send_item(offset_item(pick_offset(SPREAD_MIXED)));
    send_item(offset_item(pick_offset(SPREAD_MIXED)));
  endtask

  task automatic test_ring_wrap();
    set_threshold(10'd512);
    send_item(clear_item());
    idling_on = 1'b0;
    for (int i = 0; i < 530; i++) begin
      if (i == 256) idling_on = 1'b1;
      send_item(offset_item(pick_offset(i < RING_DEPTH ? SPREAD_LOW : SPREAD_MIXED)));
    end
  endtask

  task automatic test_random_mix();
    repeat (3) begin
      set_threshold(THR_W'($urandom_range(40, 1)));
      repeat (90) begin
        if ($urandom_range(99) < 4) begin
          send_item(clear_item());
        end else begin
          send_item(offset_item(pick_offset(SPREAD_MIXED)));
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_threshold(10'd3);
    send_item(offset_item(pick_offset(SPREAD_MIXED)));
    hold_req = 1'b1;
    wait (hold_left != 0);
    hold_req = 1'b0;
    repeat (6) send_item(offset_item(pick_offset(SPREAD_HIGH)));
  endtask

  // result side: random idling plus the long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      if (hold_req) hold_left <= HOLD_CYCLES;
      out_if.ready <= !(idling_on && $urandom_range(99) < 12);
    end
  end

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_estimates.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %p", $time, out_if.data);
        mismatch_count++;
      end else begin
        want = pending_estimates[0];
        pending_estimates.delete(0);
        check_field("mean_offset", want.mean_offset, out_if.data.mean_offset);
        check_field("smoothed_offset", want.smoothed_offset, out_if.data.smoothed_offset);
        check_field("sample_count", want.sample_count, out_if.data.sample_count);
        check_field("synchronised", want.synchronised, out_if.data.synchronised);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    hist_wr        = 0;
    hist_fill      = 0;
    hist_sum       = 0;
    smooth_est     = 0;
    sync_level     = SYNC_THR_RESET;
    mismatch_count = 0;
    idling_on      = 1'b1;
    hold_req       = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    for (int i = 0; i < RING_DEPTH; i++) offset_hist[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_field_extremes();
    test_rounding();
    test_thresholds();
    test_ring_wrap();
    test_random_mix();
    test_backpressure();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_estimates.size() != 0) begin
      $display("%0t ns: %0d results missing", $time, pending_estimates.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
